// ===== rtl/cdll_pkg.sv =====
// Package for the cursor doubly linked list: op codes, payload structs,
// sequencer states. No dependencies.
package cdll_pkg;

    typedef enum logic [4:0] {
        OP_CLEAR       = 5'd0,
        OP_INS_FIRST   = 5'd1,
        OP_INS_LAST    = 5'd2,
        OP_CUR_FIRST   = 5'd3,
        OP_CUR_LAST    = 5'd4,
        OP_RD_FIRST    = 5'd5,
        OP_RD_LAST     = 5'd6,
        OP_DEL_FIRST   = 5'd7,
        OP_DEL_LAST    = 5'd8,
        OP_DEL_AFTER   = 5'd9,
        OP_DEL_BEFORE  = 5'd10,
        OP_INS_AFTER   = 5'd11,
        OP_INS_BEFORE  = 5'd12,
        OP_RD_CUR      = 5'd13,
        OP_WR_CUR      = 5'd14,
        OP_CUR_NEXT    = 5'd15,
        OP_CUR_PREV    = 5'd16,
        OP_QUERY       = 5'd17
    } op_t;

    typedef struct packed {
        logic [4:0]         op;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               error;
        logic               cursor_active;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_RESP
    } state_t;

endpackage

// ===== rtl/cdll_mem.sv =====
// Node memory: one synchronous 1R/1W array with a registered read.
// Depends on nothing.
module cdll_mem #(
    parameter int DEPTH = 64,
    parameter int DW    = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);
    logic [DW-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/cursor_doubly_linked_list.sv =====
// Top level of the cursor doubly linked list: sequencer, pointer registers,
// and node/recycle memories. Depends on cdll_pkg and cdll_mem.
//
//  channel | ports                    | payload
//  input   | s_valid, s_ready, s_data | cdll_pkg::req_t (op, value)
//  result  | m_valid, m_ready, m_data | cdll_pkg::rsp_t
//
// A request passes through accept, link read and result before the next one is
// taken; a cursor delete that needs a second dependent link read also passes
// through a relink step, and its result follows that step.
// Reset empties the list and frees the pool at once; memories are not cleared.
// A stall on m_ready holds the result and blocks new requests.
module cursor_doubly_linked_list #(
    parameter int CAPACITY = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cdll_pkg::req_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output cdll_pkg::rsp_t   m_data
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    cdll_pkg::state_t state_reg, state_next;
    logic [4:0]        op_reg, op_next;
    logic [31:0]       val_reg, val_next;
    logic [AW-1:0]     head_reg, head_next, tail_reg, tail_next, cur_reg, cur_next;
    logic              ne_reg, ne_next, cv_reg, cv_next;
    logic [CW-1:0]     fresh_reg, fresh_next, rc_reg, rc_next;
    logic [AW-1:0]     v_reg, v_next;
    cdll_pkg::rsp_t    rsp_reg, rsp_next;

    // memory ports
    logic          val_we, nx_we, pv_we, rs_we;
    logic [AW-1:0] val_wa, nx_wa, pv_wa, rs_wa;
    logic [31:0]   val_wd;
    logic [AW-1:0] nx_wd, pv_wd, rs_wd;
    logic [AW-1:0] val_ra, nx_ra, pv_ra, rs_ra;
    logic [31:0]   val_rd;
    logic [AW-1:0] nx_rd, pv_rd, rs_rd;
    logic          nx_we2, pv_we2;
    logic [AW-1:0] nx_wa2, nx_wd2, pv_wa2, pv_wd2;

    cdll_mem #(.DEPTH(CAPACITY), .DW(32)) u_val (.aclk, .we(val_we), .waddr(val_wa),
        .wdata(val_wd), .raddr(val_ra), .rdata(val_rd));
    cdll_mem #(.DEPTH(CAPACITY), .DW(AW)) u_nxt (.aclk, .we(nx_we), .waddr(nx_wa),
        .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
    cdll_mem #(.DEPTH(CAPACITY), .DW(AW)) u_prv (.aclk, .we(pv_we), .waddr(pv_wa),
        .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));
    cdll_mem #(.DEPTH(CAPACITY), .DW(AW)) u_rcy (.aclk, .we(rs_we), .waddr(rs_wa),
        .wdata(rs_wd), .raddr(rs_ra), .rdata(rs_rd));

    // Second link write per table is registered and goes out in the following cycle
    logic          nx_pend_reg, pv_pend_reg;
    logic [AW-1:0] nx_pa_reg, nx_pd_reg, pv_pa_reg, pv_pd_reg;

    assign s_ready = (state_reg == cdll_pkg::ST_IDLE) && !nx_pend_reg && !pv_pend_reg;
    assign m_valid = (state_reg == cdll_pkg::ST_RESP);
    assign m_data  = rsp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cdll_pkg::ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            cur_reg     <= '0;
            ne_reg      <= 1'b0;
            cv_reg      <= 1'b0;
            fresh_reg   <= '0;
            rc_reg      <= '0;
            nx_pend_reg <= 1'b0;
            pv_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cur_reg     <= cur_next;
            ne_reg      <= ne_next;
            cv_reg      <= cv_next;
            fresh_reg   <= fresh_next;
            rc_reg      <= rc_next;
            nx_pend_reg <= nx_we2;
            pv_pend_reg <= pv_we2;
        end
        op_reg    <= op_next;
        val_reg   <= val_next;
        v_reg     <= v_next;
        rsp_reg   <= rsp_next;
        nx_pa_reg <= nx_wa2;
        nx_pd_reg <= nx_wd2;
        pv_pa_reg <= pv_wa2;
        pv_pd_reg <= pv_wd2;
    end

    // Allocation: recycled stack first, then fresh counter
    logic          can_alloc;
    logic          use_rc;
    logic [CW-1:0] rc_dec;
    assign use_rc    = (rc_reg != '0);
    assign can_alloc = use_rc || (fresh_reg < CW'(CAPACITY));
    assign rc_dec    = rc_reg - CW'(1);

    // Sequencer: issue reads, then modify pointers and write links back
    always_comb begin
        logic          is_ins, is_del, ins_err;
        logic [AW-1:0] n;
        logic [AW-1:0] w;
        state_next = state_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cur_next   = cur_reg;
        ne_next    = ne_reg;
        cv_next    = cv_reg;
        fresh_next = fresh_reg;
        rc_next    = rc_reg;
        v_next     = v_reg;
        rsp_next   = rsp_reg;
        val_we = 1'b0; val_wa = '0; val_wd = '0;
        nx_we  = nx_pend_reg; nx_wa = nx_pa_reg; nx_wd = nx_pd_reg;
        pv_we  = pv_pend_reg; pv_wa = pv_pa_reg; pv_wd = pv_pd_reg;
        rs_we  = 1'b0; rs_wa = '0; rs_wd = '0;
        nx_we2 = 1'b0; nx_wa2 = '0; nx_wd2 = '0;
        pv_we2 = 1'b0; pv_wa2 = '0; pv_wd2 = '0;
        val_ra = cur_reg; nx_ra = cur_reg; pv_ra = cur_reg;
        rs_ra  = rc_dec[AW-1:0];
        is_ins = 1'b0; is_del = 1'b0; ins_err = 1'b0;
        n = '0; w = '0;

        unique case (state_reg)
            cdll_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    op_next  = s_data.op;
                    val_next = s_data.value;
                    // First read: value/link of head, tail or cursor
                    case (s_data.op) inside
                        cdll_pkg::OP_RD_FIRST, cdll_pkg::OP_DEL_FIRST: begin
                            val_ra = head_reg; nx_ra = head_reg; pv_ra = head_reg;
                        end
                        cdll_pkg::OP_RD_LAST, cdll_pkg::OP_DEL_LAST: begin
                            val_ra = tail_reg; nx_ra = tail_reg; pv_ra = tail_reg;
                        end
                        default: ;
                    endcase
                    state_next = cdll_pkg::ST_RD1;
                end
            end
            cdll_pkg::ST_RD1: begin
                // Second dependent read for cursor deletes
                v_next = (op_reg == cdll_pkg::OP_DEL_AFTER) ? nx_rd : pv_rd;
                nx_ra = nx_rd; pv_ra = pv_rd;
                rsp_next = '0;
                is_ins = (op_reg == cdll_pkg::OP_INS_FIRST)
                      || (op_reg == cdll_pkg::OP_INS_LAST)
                      || (((op_reg == cdll_pkg::OP_INS_AFTER)
                           || (op_reg == cdll_pkg::OP_INS_BEFORE)) && cv_reg);
                if (is_ins && !can_alloc) ins_err = 1'b1;
                n = use_rc ? rs_rd : fresh_reg[AW-1:0];
                if (is_ins && can_alloc) begin
                    if (use_rc) rc_next = rc_dec; else fresh_next = fresh_reg + CW'(1);
                    val_we = 1'b1; val_wa = n; val_wd = val_reg;
                end
                state_next = cdll_pkg::ST_RESP;
                case (op_reg) inside
                    cdll_pkg::OP_CLEAR: begin
                        head_next = '0; tail_next = '0; cur_next = '0;
                        ne_next = 1'b0; cv_next = 1'b0;
                        fresh_next = '0; rc_next = '0;
                    end
                    cdll_pkg::OP_INS_FIRST: if (can_alloc) begin
                        nx_we = 1'b1; nx_wa = n; nx_wd = head_reg;
                        pv_we = 1'b1; pv_wa = n; pv_wd = '0;
                        if (ne_reg) begin
                            pv_we2 = 1'b1; pv_wa2 = head_reg; pv_wd2 = n;
                        end else tail_next = n;
                        head_next = n; ne_next = 1'b1;
                    end
                    cdll_pkg::OP_INS_LAST: if (can_alloc) begin
                        pv_we = 1'b1; pv_wa = n; pv_wd = tail_reg;
                        nx_we = 1'b1; nx_wa = n; nx_wd = '0;
                        if (ne_reg) begin
                            nx_we2 = 1'b1; nx_wa2 = tail_reg; nx_wd2 = n;
                        end else head_next = n;
                        tail_next = n; ne_next = 1'b1;
                    end
                    cdll_pkg::OP_CUR_FIRST: begin cur_next = head_reg; cv_next = ne_reg; end
                    cdll_pkg::OP_CUR_LAST:  begin cur_next = tail_reg; cv_next = ne_reg; end
                    cdll_pkg::OP_RD_FIRST, cdll_pkg::OP_RD_LAST: begin
                        if (!ne_reg) rsp_next.error = 1'b1;
                        else rsp_next.read_value = val_rd;
                    end
                    cdll_pkg::OP_RD_CUR: begin
                        if (!cv_reg) rsp_next.error = 1'b1;
                        else rsp_next.read_value = val_rd;
                    end
                    cdll_pkg::OP_DEL_FIRST, cdll_pkg::OP_DEL_LAST: if (ne_reg) begin
                        is_del = 1'b1;
                        v_next = (op_reg == cdll_pkg::OP_DEL_FIRST) ? head_reg : tail_reg;
                        if (cv_reg && cur_reg == v_next) cv_next = 1'b0;
                        if (head_reg == tail_reg) begin
                            ne_next = 1'b0; cv_next = 1'b0;
                            head_next = '0; tail_next = '0;
                        end else if (op_reg == cdll_pkg::OP_DEL_FIRST) begin
                            pv_we = 1'b1; pv_wa = nx_rd; pv_wd = '0; head_next = nx_rd;
                        end else begin
                            nx_we = 1'b1; nx_wa = pv_rd; nx_wd = '0; tail_next = pv_rd;
                        end
                    end
                    cdll_pkg::OP_DEL_AFTER: if (cv_reg && cur_reg != tail_reg) begin
                        is_del = 1'b1;
                        if (nx_rd == tail_reg) begin
                            tail_next = cur_reg;
                            nx_we = 1'b1; nx_wa = cur_reg; nx_wd = '0;
                        end else state_next = cdll_pkg::ST_RD2;
                    end
                    cdll_pkg::OP_DEL_BEFORE: if (cv_reg && cur_reg != head_reg) begin
                        is_del = 1'b1;
                        if (pv_rd == head_reg) begin
                            head_next = cur_reg;
                            pv_we = 1'b1; pv_wa = cur_reg; pv_wd = '0;
                        end else state_next = cdll_pkg::ST_RD2;
                    end
                    cdll_pkg::OP_INS_AFTER: if (cv_reg && can_alloc) begin
                        w = (cur_reg == tail_reg) ? '0 : nx_rd;
                        if (cur_reg == tail_reg) tail_next = n;
                        else begin pv_we2 = 1'b1; pv_wa2 = nx_rd; pv_wd2 = n; end
                        nx_we = 1'b1; nx_wa = n; nx_wd = w;
                        pv_we = 1'b1; pv_wa = n; pv_wd = cur_reg;
                        nx_we2 = 1'b1; nx_wa2 = cur_reg; nx_wd2 = n;
                    end
                    cdll_pkg::OP_INS_BEFORE: if (cv_reg && can_alloc) begin
                        w = (cur_reg == head_reg) ? '0 : pv_rd;
                        if (cur_reg == head_reg) head_next = n;
                        else begin nx_we2 = 1'b1; nx_wa2 = pv_rd; nx_wd2 = n; end
                        pv_we = 1'b1; pv_wa = n; pv_wd = w;
                        nx_we = 1'b1; nx_wa = n; nx_wd = cur_reg;
                        pv_we2 = 1'b1; pv_wa2 = cur_reg; pv_wd2 = n;
                    end
                    cdll_pkg::OP_WR_CUR: if (cv_reg) begin
                        val_we = 1'b1; val_wa = cur_reg; val_wd = val_reg;
                    end
                    cdll_pkg::OP_CUR_NEXT: if (cv_reg) begin
                        if (cur_reg == tail_reg) cv_next = 1'b0; else cur_next = nx_rd;
                    end
                    cdll_pkg::OP_CUR_PREV: if (cv_reg) begin
                        if (cur_reg == head_reg) cv_next = 1'b0; else cur_next = pv_rd;
                    end
                    default: ;
                endcase
                rsp_next.error = rsp_next.error | ins_err;
                rsp_next.cursor_active = cv_next;
                // Push freed node (never with a pending insert, so rc only grows)
                if (is_del && rc_reg < CW'(CAPACITY)) begin
                    rs_we = 1'b1; rs_wa = rc_reg[AW-1:0]; rs_wd = v_next;
                    rc_next = rc_reg + CW'(1);
                end
            end
            cdll_pkg::ST_RD2: begin
                // Relink around the deleted neighbor
                if (op_reg == cdll_pkg::OP_DEL_AFTER) begin
                    nx_we = 1'b1; nx_wa = cur_reg; nx_wd = nx_rd;
                    pv_we = 1'b1; pv_wa = nx_rd; pv_wd = cur_reg;
                end else begin
                    pv_we = 1'b1; pv_wa = cur_reg; pv_wd = pv_rd;
                    nx_we = 1'b1; nx_wa = pv_rd; nx_wd = cur_reg;
                end
                state_next = cdll_pkg::ST_RESP;
            end
            cdll_pkg::ST_RESP: begin
                if (m_ready) state_next = cdll_pkg::ST_IDLE;
            end
            default: state_next = cdll_pkg::ST_IDLE;
        endcase
    end
endmodule
